@@ src/oqd_pkg.sv @@
// Shared types, constants and helper functions for the offset-QPSK demodulator.
// Used by oqd_tap_cell, oqpsk_coherent_demodulator and oqd_checker; no dependencies.
package oqd_pkg;

	localparam int SAMPLE_BITS        = 16;
	localparam int DEF_NUM_TAPS       = 32;
	localparam int DEF_MAX_SPS        = 16;
	localparam int DEF_NCO_TABLE_BITS = 10;

	localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
	localparam logic signed [30:0] TURN_PER_RAD = 31'sd683565276;
	localparam logic signed [15:0] ONE_Q15      = 16'sd32767;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPS  = 3'd0,
		CFG_DPT  = 3'd1,
		CFG_EN   = 3'd2,
		CFG_KP   = 3'd3,
		CFG_KI   = 3'd4,
		CFG_FUP  = 3'd5,
		CFG_FLO  = 3'd6
	} cfg_reg_t;

	localparam logic [4:0]  RST_SPS = 5'd8;
	localparam logic [3:0]  RST_DPT = 4'd4;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} cplx_t;

	localparam cplx_t CPLX_ONE  = '{re: ONE_Q15, im: 16'sd0};
	localparam cplx_t CPLX_ZERO = '{re: 16'sd0, im: 16'sd0};

	typedef struct packed {
		logic                          action;
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
		logic                          restart_symbol;
		logic                          load_freq;
		logic signed [31:0]            freq_value;
		logic                          load_phase;
		logic signed [31:0]            phase_value;
		logic [4:0]                    coef_index;
		logic signed [15:0]            coef_re;
		logic signed [15:0]            coef_im;
	} in_t;

	typedef struct packed {
		logic signed [15:0] symbol_i;
		logic signed [15:0] symbol_q;
	} out_t;

	// controls for one filter cell
	typedef struct packed {
		logic shift;
		logic load_coef;
	} cell_ctl_t;

	// round half up by n bits, then saturate to 16 bits
	function automatic logic signed [15:0] rnd_sat16(logic signed [63:0] v, int unsigned n);
		logic signed [63:0] t;
		t = (v + (64'sd1 <<< (n - 1))) >>> n;
		if (t > 64'sd32767)
			return 16'sd32767;
		else if (t < -64'sd32768)
			return -16'sd32768;
		return t[15:0];
	endfunction

	// sin(pi/2 * u / 2^(tbits-2)) in Q1.15, Taylor series in Q30; elaboration only
	function automatic logic [15:0] quarter_sine(int unsigned u, int unsigned tbits);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] s;
		y   = (64'(u) * HALF_PI_Q30) >> (tbits - 2);
		y2  = (y * y) >> 30;
		acc = 64'd1 << 30;
		for (int k = 0; k < 6; k++) begin
			t = (y2 * acc) >> 30;
			case (k)
				0: t = t / 64'd156;
				1: t = t / 64'd110;
				2: t = t / 64'd72;
				3: t = t / 64'd42;
				4: t = t / 64'd20;
				default: t = t / 64'd6;
			endcase
			acc = (64'd1 << 30) - t;
		end
		s = (y * acc) >> 30;
		s = (s + (64'd1 << 14)) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		return s[15:0];
	endfunction

endpackage

@@ src/oqd_tap_cell.sv @@
// One matched-filter cell: holds a mixed sample and a tap, forms their product
// and adds it to the partial sum from its left neighbor. Depends on oqd_pkg.
module oqd_tap_cell #(
	parameter int ACC_W = 38
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  oqd_pkg::cell_ctl_t       ctl,
	input  oqd_pkg::cplx_t           coef_in,
	input  oqd_pkg::cplx_t           mix_in,
	output oqd_pkg::cplx_t           mix_out,
	input  logic signed [ACC_W-1:0]  acc_in_re,
	input  logic signed [ACC_W-1:0]  acc_in_im,
	output logic signed [ACC_W-1:0]  acc_out_re,
	output logic signed [ACC_W-1:0]  acc_out_im
);

	oqd_pkg::cplx_t mix_q;
	oqd_pkg::cplx_t coef_q;
	logic signed [32:0] prod_re_q;
	logic signed [32:0] prod_im_q;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;
	logic signed [31:0] rr, ii, ri, ir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q  <= oqd_pkg::CPLX_ONE;
			coef_q <= oqd_pkg::CPLX_ZERO;
		end else begin
			if (ctl.shift)
				mix_q <= mix_in;
			if (ctl.load_coef)
				coef_q <= coef_in;
		end
	end

	always_comb begin
		rr = mix_q.re * coef_q.re;
		ii = mix_q.im * coef_q.im;
		ri = mix_q.re * coef_q.im;
		ir = mix_q.im * coef_q.re;
	end

	// product stage, then accumulate along the row
	always_ff @(posedge clk) begin
		prod_re_q <= 33'(rr) - 33'(ii);
		prod_im_q <= 33'(ri) + 33'(ir);
		acc_re_q  <= acc_in_re + ACC_W'(prod_re_q);
		acc_im_q  <= acc_in_im + ACC_W'(prod_im_q);
	end

	assign mix_out    = mix_q;
	assign acc_out_re = acc_re_q;
	assign acc_out_im = acc_im_q;

endmodule

@@ src/oqpsk_coherent_demodulator.sv @@
// Top level of the offset-QPSK coherent demodulator with carrier loop.
// Depends on oqd_pkg and oqd_tap_cell.
//
//  port group   direction  transaction
//  in_*         input      one sample or one filter coefficient (oqd_pkg::in_t)
//  out_*        output     one offset-QPSK symbol pair (oqd_pkg::out_t)
//  cfg_*        input      one register write (index, 32-bit data)
//
// A sample occupies the block through NCO lookup, the mixer, the ripple of the
// partial sum down the row of tap cells, then decision, error and the gain,
// frequency and phase updates of the loop.
// A coefficient write goes straight to its tap cell. cfg_ready is always high.
// Reset clears the delay lines to one, taps to zero and the loop state at once.
// A symbol waits in the output register; the block stalls at the decision
// step only if a new symbol is due while the previous one is still held.
module oqpsk_coherent_demodulator #(
	parameter int NUM_TAPS       = oqd_pkg::DEF_NUM_TAPS,
	parameter int MAX_SPS        = oqd_pkg::DEF_MAX_SPS,
	parameter int NCO_TABLE_BITS = oqd_pkg::DEF_NCO_TABLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  oqd_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output oqd_pkg::out_t                      out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [oqd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [oqd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ACC_W  = 33 + $clog2(NUM_TAPS);
	localparam int HIST   = MAX_SPS / 2 + 1;
	localparam int HALF_W = $clog2(HIST);
	localparam int SPS_C  = $clog2(MAX_SPS + 1);
	localparam int SPS_W  = (SPS_C > 5) ? SPS_C : 5;
	localparam int POS_W  = $clog2(MAX_SPS);
	localparam int CMP_W  = (POS_W > 4) ? POS_W : 4;
	localparam int CNT_W  = $clog2(NUM_TAPS + 2);
	localparam int TB     = NCO_TABLE_BITS;
	localparam int QN     = 1 << (TB - 2);

	typedef enum logic [3:0] {
		S_IDLE, S_NCO, S_MIX1, S_MIX2, S_FIR, S_DEC, S_ERR,
		S_G1, S_G2, S_G3, S_FRQ, S_PHS
	} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0]         sps_q;
	logic [3:0]         dpt_q;
	logic               en_q;
	logic [31:0]        kp_q;
	logic [31:0]        ki_q;
	logic signed [31:0] fup_q;
	logic signed [31:0] flo_q;

	// loop state
	logic [POS_W-1:0]   pos_q;
	logic signed [31:0] freq_q;
	logic [31:0]        phase_q;
	oqd_pkg::cplx_t     flt_q [HIST];
	logic               out_valid_q;
	oqd_pkg::out_t      out_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               hit_q;

	// datapath registers
	logic signed [15:0] x_q, y_q, c_q, s_q;
	logic signed [31:0] xc_q, ys_q, yc_q, xs_q;
	logic signed [31:0] p1_q, p2_q, err_q;
	logic signed [64:0] gi_q, gp_q;
	logic signed [34:0] radi_q, radp_q;
	logic signed [41:0] termi_q, termp_q;

	logic in_acc;
	logic cfg_acc;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q <= oqd_pkg::RST_SPS;
			dpt_q <= oqd_pkg::RST_DPT;
			en_q  <= 1'b1;
			kp_q  <= '0;
			ki_q  <= '0;
			fup_q <= 32'sh7fffffff;
			flo_q <= 32'sh80000000;
		end else if (cfg_acc) begin
			case (oqd_pkg::cfg_reg_t'(cfg_index))
				oqd_pkg::CFG_SPS: sps_q <= cfg_data[4:0];
				oqd_pkg::CFG_DPT: dpt_q <= cfg_data[3:0];
				oqd_pkg::CFG_EN:  en_q  <= cfg_data[0];
				oqd_pkg::CFG_KP:  kp_q  <= cfg_data;
				oqd_pkg::CFG_KI:  ki_q  <= cfg_data;
				oqd_pkg::CFG_FUP: fup_q <= $signed(cfg_data);
				oqd_pkg::CFG_FLO: flo_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// clamp samples per symbol to the supported range
	logic [SPS_W-1:0]  sps_eff;
	logic [HALF_W-1:0] half;
	always_comb begin
		sps_eff = SPS_W'(sps_q);
		if (sps_eff < SPS_W'(2))
			sps_eff = SPS_W'(2);
		else if (sps_eff > SPS_W'(MAX_SPS))
			sps_eff = SPS_W'(MAX_SPS);
		half = HALF_W'(sps_eff >> 1);
	end

	logic hit;
	logic [SPS_W-1:0] pos_inc;
	assign hit     = (CMP_W'(pos_q) == CMP_W'(dpt_q));
	assign pos_inc = SPS_W'(pos_q) + SPS_W'(1);

	// quarter-wave sine table, built at elaboration
	logic [15:0] qtab [QN+1];
	for (genvar g = 0; g <= QN; g++) begin : g_qtab
		assign qtab[g] = oqd_pkg::quarter_sine(g, TB);
	end

	logic [TB-1:0]       nco_idx;
	logic [TB-3:0]       nco_r;
	logic [1:0]          nco_quad;
	logic signed [15:0]  nco_a, nco_b, nco_c, nco_s;
	always_comb begin
		nco_idx  = phase_q[31 -: TB];
		nco_r    = nco_idx[TB-3:0];
		nco_quad = nco_idx[TB-1 -: 2];
		nco_a    = $signed(qtab[{1'b0, nco_r}]);
		nco_b    = $signed(qtab[(TB-1)'(QN) - {1'b0, nco_r}]);
		case (nco_quad)
			2'd0: begin nco_s = nco_a;  nco_c = nco_b;  end
			2'd1: begin nco_s = nco_b;  nco_c = -nco_a; end
			2'd2: begin nco_s = -nco_a; nco_c = -nco_b; end
			default: begin nco_s = -nco_b; nco_c = nco_a; end
		endcase
	end

	// mixer output, rounded by SAMPLE_BITS-1 and saturated
	oqd_pkg::cplx_t mix_new;
	always_comb begin
		mix_new.re = oqd_pkg::rnd_sat16(64'(xc_q) + 64'(ys_q), oqd_pkg::SAMPLE_BITS - 1);
		mix_new.im = oqd_pkg::rnd_sat16(64'(yc_q) - 64'(xs_q), oqd_pkg::SAMPLE_BITS - 1);
	end

	// row of tap cells
	oqd_pkg::cell_ctl_t      ctl [NUM_TAPS];
	oqd_pkg::cplx_t          mix_chain [NUM_TAPS+1];
	logic signed [ACC_W-1:0] acc_re [NUM_TAPS+1];
	logic signed [ACC_W-1:0] acc_im [NUM_TAPS+1];
	oqd_pkg::cplx_t          coef_w;

	assign coef_w              = '{re: in_data.coef_re, im: in_data.coef_im};
	assign mix_chain[NUM_TAPS] = mix_new;
	assign acc_re[0]           = '0;
	assign acc_im[0]           = '0;

	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
		assign ctl[k].shift     = (state_q == S_MIX2);
		assign ctl[k].load_coef = in_acc && in_data.action &&
			(32'(in_data.coef_index) == 32'(k));
		oqd_tap_cell #(.ACC_W(ACC_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[k]),
			.coef_in    (coef_w),
			.mix_in     (mix_chain[k+1]),
			.mix_out    (mix_chain[k]),
			.acc_in_re  (acc_re[k]),
			.acc_in_im  (acc_im[k]),
			.acc_out_re (acc_re[k+1]),
			.acc_out_im (acc_im[k+1])
		);
	end

	oqd_pkg::cplx_t flt_new;
	always_comb begin
		flt_new.re = oqd_pkg::rnd_sat16(64'(acc_re[NUM_TAPS]), 15);
		flt_new.im = oqd_pkg::rnd_sat16(64'(acc_im[NUM_TAPS]), 15);
	end

	oqd_pkg::cplx_t newest, oldest;
	assign newest = flt_q[half];
	assign oldest = flt_q[0];

	// loop arithmetic
	logic signed [64:0] gi_c, gp_c, gi_r, gp_r;
	logic signed [65:0] ti_c, tp_c;
	logic signed [42:0] fsum;
	always_comb begin
		gi_c = $signed({1'b0, ki_q}) * err_q;
		gp_c = $signed({1'b0, kp_q}) * err_q;
		gi_r = (gi_q + (65'sd1 <<< 29)) >>> 30;
		gp_r = (gp_q + (65'sd1 <<< 29)) >>> 30;
		ti_c = radi_q * oqd_pkg::TURN_PER_RAD;
		tp_c = radp_q * oqd_pkg::TURN_PER_RAD;
		fsum = 43'(freq_q) + 43'(termi_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			freq_q      <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < HIST; k++)
				flt_q[k] <= oqd_pkg::CPLX_ONE;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					// coefficient writes go straight to the cells
					if (in_acc && !in_data.action) begin
						if (in_data.restart_symbol)
							pos_q <= '0;
						if (in_data.load_freq)
							freq_q <= in_data.freq_value;
						if (in_data.load_phase)
							phase_q <= in_data.phase_value;
						state_q <= S_NCO;
					end
				end
				S_NCO:  state_q <= S_MIX1;
				S_MIX1: state_q <= S_MIX2;
				S_MIX2: begin
					cnt_q   <= '0;
					state_q <= S_FIR;
				end
				S_FIR: begin
					// wait for the sum to reach the end of the row
					if (cnt_q == CNT_W'(NUM_TAPS + 1)) begin
						for (int k = 0; k < HIST - 1; k++)
							if (k < int'(half))
								flt_q[k] <= flt_q[k+1];
						for (int k = 0; k < HIST; k++)
							if (k == int'(half))
								flt_q[k] <= flt_new;
						state_q <= S_DEC;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DEC: begin
					// hold while a new symbol is due and the previous one is still waiting
					if (!(hit && out_valid_q && !out_ready)) begin
						hit_q <= hit;
						if (hit) begin
							out_valid_q    <= 1'b1;
							out_q.symbol_i <= oldest.im;
							out_q.symbol_q <= newest.re;
						end
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (pos_inc >= sps_eff)
						pos_q <= '0;
					else
						pos_q <= POS_W'(pos_inc);
					state_q <= S_G1;
				end
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_G3;
				S_G3: state_q <= S_FRQ;
				S_FRQ: begin
					if (en_q) begin
						if (fsum > 43'(fup_q))
							freq_q <= fup_q;
						else if (fsum < 43'(flo_q))
							freq_q <= flo_q;
						else
							freq_q <= fsum[31:0];
					end
					state_q <= S_PHS;
				end
				S_PHS: begin
					if (en_q)
						phase_q <= phase_q + freq_q + termp_q[31:0];
					else
						phase_q <= phase_q + freq_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= in_data.sample_i;
			y_q <= in_data.sample_q;
		end
		if (state_q == S_NCO) begin
			c_q <= nco_c;
			s_q <= nco_s;
		end
		if (state_q == S_MIX1) begin
			xc_q <= x_q * c_q;
			ys_q <= y_q * s_q;
			yc_q <= y_q * c_q;
			xs_q <= x_q * s_q;
		end
		if (state_q == S_DEC) begin
			p1_q <= newest.re * newest.im;
			p2_q <= oldest.re * oldest.im;
		end
		if (state_q == S_ERR)
			err_q <= hit_q ? (p1_q - p2_q) : 32'sd0;
		if (state_q == S_G1) begin
			gi_q <= gi_c;
			gp_q <= gp_c;
		end
		if (state_q == S_G2) begin
			radi_q <= 35'(gi_r);
			radp_q <= 35'(gp_r);
		end
		if (state_q == S_G3) begin
			termi_q <= 42'((ti_c + (66'sd1 <<< 23)) >>> 24);
			termp_q <= 42'((tp_c + (66'sd1 <<< 23)) >>> 24);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/oqd_checker.sv @@
// Port-level checks for the offset-QPSK demodulator, bound to its top level.
// Depends on oqd_pkg and oqpsk_coherent_demodulator.
module oqd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input oqd_pkg::in_t                   in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input oqd_pkg::out_t                  out_data,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [oqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [oqd_pkg::CFG_DATA_W-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("held symbol changed before transaction");

	a_coef_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.action |=> !$rose(out_valid))
		else $error("coefficient write produced a symbol");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.action |=> !in_ready)
		else $error("sample did not occupy the block");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("symbol appeared while idle");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind oqpsk_coherent_demodulator oqd_checker u_oqd_checker (.*);
